[design/mfa_pkg.sv]
// shared types and constants for the mixed fraction adder
`default_nettype none
package mfa_pkg;
    localparam int OPERAND_BITS = 16;
    localparam int PROD_BITS    = 2 * OPERAND_BITS;
    localparam int WHOLE_BITS   = 48;
    localparam int FRAC_BITS    = 32;
    localparam int CNT_BITS     = $clog2(PROD_BITS + 1);

    // sequencer states, one-hot
    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_DIVA = 7'b0000010,
        S_DIVB = 7'b0000100,
        S_MUL  = 7'b0001000,
        S_GCD  = 7'b0010000,
        S_RED  = 7'b0100000,
        S_OUT  = 7'b1000000
    } t_state;

    // divider control and status
    typedef struct packed {
        logic start;
    } t_div_ctl;
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;
endpackage
`default_nettype wire

[design/mfa_divider.sv]
// restoring divider, one quotient bit per cycle, unsigned prod-width operands
`default_nettype none
module mfa_divider
    import mfa_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_div_ctl             i_ctl,
    input  wire logic [PROD_BITS-1:0] i_dividend,
    input  wire logic [PROD_BITS-1:0] i_divisor,
    output t_div_sts                  o_sts,
    output logic [PROD_BITS-1:0]      o_quot,
    output logic [PROD_BITS-1:0]      o_rem
);
    logic [PROD_BITS-1:0] r_q, r_d;
    logic [PROD_BITS:0]   r_r, n_r, trial;
    logic [CNT_BITS-1:0]  r_cnt;
    logic                 r_busy, r_done;

    // shift in next dividend bit and trial subtract
    always_comb begin
        n_r   = {r_r[PROD_BITS-1:0], r_q[PROD_BITS-1]};
        trial = n_r - {1'b0, r_d};
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_BITS'(PROD_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_q <= i_dividend;
            r_d <= i_divisor;
            r_r <= '0;
        end else if (r_busy) begin
            if (!trial[PROD_BITS]) begin
                r_r <= trial;
                r_q <= {r_q[PROD_BITS-2:0], 1'b1};
            end else begin
                r_r <= n_r;
                r_q <= {r_q[PROD_BITS-2:0], 1'b0};
            end
        end
    end

    assign o_sts  = '{busy: r_busy, done: r_done};
    assign o_quot = r_q;
    assign o_rem  = r_r[PROD_BITS-1:0];
endmodule
`default_nettype wire

[design/mixed_fraction_adder.sv]
// top level: sum of two mixed fractions with gcd reduction
// steps: two floor splits, the products, one divide per euclid step (at most 46 for
// 32-bit values) and two reduction divides, then the result register; a zero fraction
// part skips the euclid and reduction divides, a zero denominator skips all divides
// throughput: one word at a time, a new word is taken once the last result is registered
// all divides run through one shared bit-serial divider
// reset: synchronous active low, returns to idle with no result pending
`default_nettype none
module mixed_fraction_adder
    import mfa_pkg::*;
(
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_stall,
    input  wire logic signed [OPERAND_BITS-1:0] i_a_whole,
    input  wire logic signed [OPERAND_BITS-1:0] i_a_num,
    input  wire logic        [OPERAND_BITS-1:0] i_a_den,
    input  wire logic signed [OPERAND_BITS-1:0] i_b_whole,
    input  wire logic signed [OPERAND_BITS-1:0] i_b_num,
    input  wire logic        [OPERAND_BITS-1:0] i_b_den,
    output logic                                o_valid,
    input  wire logic                           i_stall,
    output logic                                o_div_error,
    output logic                                o_negative,
    output logic [WHOLE_BITS-1:0]               o_whole_mag,
    output logic [FRAC_BITS-1:0]                o_frac_num,
    output logic [FRAC_BITS-1:0]                o_frac_den
);
    localparam int WB = PROD_BITS + 2;  // signed whole accumulator

    t_state r_state;
    logic [OPERAND_BITS-1:0] r_ad, r_bd, r_an, r_bn;
    logic signed [WB-1:0]    r_w;
    logic [OPERAND_BITS-1:0] r_ra;
    logic [PROD_BITS-1:0]    r_s, r_den, r_gx, r_gy;
    logic                    r_neg, r_red2;
    logic                    r_ovalid, r_err;
    logic [WHOLE_BITS-1:0]   r_mag;
    logic [FRAC_BITS-1:0]    r_fn, r_fd;
    logic                    r_oerr, r_oneg;
    logic [WHOLE_BITS-1:0]   r_omag;
    logic [FRAC_BITS-1:0]    r_ofn, r_ofd;
    logic                    out_load;

    t_div_sts             div_sts;
    logic [PROD_BITS-1:0] div_a, div_b, div_q, div_r;
    logic [PROD_BITS-1:0] mag_num, floor_q, floor_r;
    logic [OPERAND_BITS-1:0] mag16;
    logic signed [WB-1:0] floor_qs;
    logic                 cur_neg;
    logic [OPERAND_BITS-1:0] cur_num, cur_den;
    logic [PROD_BITS:0]   fsum;
    logic [PROD_BITS-1:0] p_den, p_s1, p_s2;
    logic signed [WB-1:0] w_adj;
    logic [PROD_BITS-1:0] s_adj;
    logic                 accept;

    t_div_ctl             div_ctl_q;
    logic [PROD_BITS-1:0] r_da, r_db;
    logic                 r_go;

    assign accept  = i_valid && !o_stall;
    assign o_stall = (r_state != S_IDLE);

    // floor split of the numerator in flight: magnitude divide then sign fixup
    always_comb begin
        cur_num = (r_state == S_DIVB) ? r_bn : r_an;
        cur_den = (r_state == S_DIVB) ? r_bd : r_ad;
        cur_neg = cur_num[OPERAND_BITS-1];
        mag16   = cur_neg ? (~cur_num + 1'b1) : cur_num;
        mag_num = PROD_BITS'(mag16);
        floor_q  = div_q;
        floor_r  = div_r;
        floor_qs = WB'(floor_q);
        if (cur_neg) begin
            floor_qs = -WB'(floor_q);
            if (div_r != '0) begin
                floor_qs = floor_qs - 1;
                floor_r  = PROD_BITS'(cur_den) - div_r;
            end
        end
    end

    // divider operand select
    always_comb begin
        div_a = mag_num;
        div_b = PROD_BITS'(cur_den);
        unique case (r_state)
            S_GCD: begin
                div_a = r_gx;
                div_b = r_gy;
            end
            S_RED: begin
                div_a = r_red2 ? r_den : r_s;
                div_b = r_gx;
            end
            default: ;
        endcase
    end

    // cross products and carry out of the fraction sum
    always_comb begin
        p_den = PROD_BITS'(r_ad) * PROD_BITS'(r_bd);
        p_s1  = PROD_BITS'(r_ra) * PROD_BITS'(r_bd);
        p_s2  = PROD_BITS'(r_bn) * PROD_BITS'(r_ad);
        fsum  = {1'b0, p_s1} + {1'b0, p_s2};
        w_adj = r_w;
        s_adj = fsum[PROD_BITS-1:0];
        if (fsum >= {1'b0, p_den}) begin
            s_adj = PROD_BITS'(fsum - {1'b0, p_den});
            w_adj = r_w + 1;
        end
    end

    mfa_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (div_ctl_q),
        .i_dividend (r_da),
        .i_divisor  (r_db),
        .o_sts      (div_sts),
        .o_quot     (div_q),
        .o_rem      (div_r)
    );

    // registered divider launch so operands are stable
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            div_ctl_q <= '0;
        end else begin
            div_ctl_q.start <= r_go;
        end
        r_da <= div_a;
        r_db <= div_b;
    end

    // result register is free or being emptied this cycle
    assign out_load = (r_state == S_OUT) && (!r_ovalid || !i_stall);

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_go     <= 1'b0;
        end else begin
            r_go <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_an <= i_a_num;
                        r_bn <= i_b_num;
                        r_ad <= i_a_den;
                        r_bd <= i_b_den;
                        r_w  <= WB'(i_a_whole) + WB'(i_b_whole);
                        if (i_a_den == '0 || i_b_den == '0) begin
                            r_err   <= 1'b1;
                            r_neg   <= 1'b0;
                            r_mag   <= '0;
                            r_fn    <= '0;
                            r_fd    <= '0;
                            r_state <= S_OUT;
                        end else begin
                            r_err   <= 1'b0;
                            r_go    <= 1'b1;
                            r_state <= S_DIVA;
                        end
                    end
                end
                S_DIVA: begin
                    if (div_sts.done) begin
                        r_ra    <= OPERAND_BITS'(floor_r);
                        r_w     <= r_w + floor_qs;
                        r_go    <= 1'b1;
                        r_state <= S_DIVB;
                    end
                end
                S_DIVB: begin
                    if (div_sts.done) begin
                        r_bn    <= OPERAND_BITS'(floor_r);
                        r_w     <= r_w + floor_qs;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_den <= p_den;
                    if (w_adj >= 0) begin
                        r_neg <= 1'b0;
                        r_mag <= WHOLE_BITS'(w_adj);
                        r_s   <= s_adj;
                    end else if (s_adj == '0) begin
                        r_neg <= 1'b1;
                        r_mag <= WHOLE_BITS'(-w_adj);
                        r_s   <= s_adj;
                    end else begin
                        r_neg <= 1'b1;
                        r_mag <= WHOLE_BITS'(-w_adj - 1);
                        r_s   <= p_den - s_adj;
                    end
                    r_gx <= p_den;
                    r_gy <= (w_adj < 0 && s_adj != '0) ? p_den - s_adj : s_adj;
                    if ((w_adj < 0 && s_adj != '0) || s_adj != '0) begin
                        r_go    <= 1'b1;
                        r_state <= S_GCD;
                    end else begin
                        r_fn    <= '0;
                        r_fd    <= FRAC_BITS'(1);
                        r_state <= S_OUT;
                    end
                end
                S_GCD: begin
                    if (div_sts.done) begin
                        if (div_r == '0) begin
                            r_gx    <= r_gy;
                            r_red2  <= 1'b0;
                            r_go    <= 1'b1;
                            r_state <= S_RED;
                        end else begin
                            r_gx <= r_gy;
                            r_gy <= div_r;
                            r_go <= 1'b1;
                        end
                    end
                end
                S_RED: begin
                    if (div_sts.done) begin
                        if (!r_red2) begin
                            r_fn   <= FRAC_BITS'(div_q);
                            r_red2 <= 1'b1;
                            r_go   <= 1'b1;
                        end else begin
                            r_fd    <= FRAC_BITS'(div_q);
                            r_state <= S_OUT;
                        end
                    end
                end
                S_OUT: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (out_load) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    // result word, held while the receiver stalls
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_oerr <= r_err;
            r_oneg <= r_neg;
            r_omag <= r_mag;
            r_ofn  <= r_fn;
            r_ofd  <= r_fd;
        end
    end

    assign o_valid     = r_ovalid;
    assign o_div_error = r_oerr;
    assign o_negative  = r_oneg;
    assign o_whole_mag = r_omag;
    assign o_frac_num  = r_ofn;
    assign o_frac_den  = r_ofd;

    // checks
    unused_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_state != S_IDLE) else $error("accept did not leave idle");
    one_hot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state)) else $error("state not one-hot");
    frac_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_div_error) |-> (o_frac_num < o_frac_den))
        else $error("fraction not proper");
    err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_div_error) |-> (o_frac_den == '0 && o_whole_mag == '0))
        else $error("error result not cleared");
endmodule
`default_nettype wire

[tb/mixed_fraction_adder_test.sv]
// self-checking testbench for the mixed fraction adder
`timescale 1ns / 100ps
`default_nettype none
module mixed_fraction_adder_test;
    import mfa_pkg::*;

    typedef struct {
        logic                     div_error;
        logic                     negative;
        logic [WHOLE_BITS-1:0]    whole_mag;
        logic [FRAC_BITS-1:0]     frac_num;
        logic [FRAC_BITS-1:0]     frac_den;
    } t_sum;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_stall = 1'b0;
    logic o_stall, o_valid, o_div_error, o_negative;
    logic signed [OPERAND_BITS-1:0] i_a_whole = '0, i_a_num = '0, i_b_whole = '0, i_b_num = '0;
    logic [OPERAND_BITS-1:0] i_a_den = '0, i_b_den = '0;
    logic [WHOLE_BITS-1:0] o_whole_mag;
    logic [FRAC_BITS-1:0] o_frac_num, o_frac_den;

    t_sum sum_queue[$];
    int   fail_count = 0;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    int   hold_cycles = 0;

    mixed_fraction_adder u_dut (.*);

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // exact sum of two mixed fractions in sign-magnitude form
    function automatic t_sum predict_sum(longint aw, longint an, longint ad,
                                         longint bw, longint bn, longint bd);
        t_sum r;
        longint qa, qb, ra, rb, w;
        longint unsigned dn, s, x, y, t, mag;
        r = '{default: '0};
        if (ad == 0 || bd == 0) begin
            r.div_error = 1'b1;
            return r;
        end
        qa = an / ad;
        ra = an % ad;
        if (ra < 0) begin
            ra += ad;
            qa -= 1;
        end
        qb = bn / bd;
        rb = bn % bd;
        if (rb < 0) begin
            rb += bd;
            qb -= 1;
        end
        w = aw + bw + qa + qb;
        dn = ad * bd;
        s = ra * bd + rb * ad;
        if (s >= dn) begin
            s -= dn;
            w += 1;
        end
        if (w >= 0) begin
            mag = w;
        end else begin
            r.negative = 1'b1;
            if (s == 0) begin
                mag = -w;
            end else begin
                mag = -w - 1;
                s = dn - s;
            end
        end
        if (s == 0) begin
            dn = 1;
        end else begin
            x = s;
            y = dn;
            while (y != 0) begin
                t = x % y;
                x = y;
                y = t;
            end
            s /= x;
            dn /= x;
        end
        r.whole_mag = WHOLE_BITS'(mag);
        r.frac_num = FRAC_BITS'(s);
        r.frac_den = FRAC_BITS'(dn);
        return r;
    endfunction

    // send one word and queue its expected sum
    task automatic send_word(longint aw, longint an, longint ad,
                             longint bw, longint bn, longint bd);
        while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_a_whole <= OPERAND_BITS'(aw);
        i_a_num <= OPERAND_BITS'(an);
        i_a_den <= OPERAND_BITS'(ad);
        i_b_whole <= OPERAND_BITS'(bw);
        i_b_num <= OPERAND_BITS'(bn);
        i_b_den <= OPERAND_BITS'(bd);
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sum_queue.push_back(predict_sum(aw, an, ad, bw, bn, bd));
    endtask

    task automatic send_random;
        longint aw, an, ad, bw, bn, bd;
        int m;
        m = $urandom_range(9, 0);
        aw = $signed(16'($urandom));
        bw = $signed(16'($urandom));
        an = $signed(16'($urandom));
        bn = $signed(16'($urandom));
        ad = 16'($urandom);
        bd = 16'($urandom);
        // small values when m is below 4, so reductions and carries are common
        if (m < 4) begin
            aw = $signed(5'($urandom));
            bw = $signed(5'($urandom));
            ad = $urandom_range(12, 1);
            bd = $urandom_range(12, 1);
            an = $signed(6'($urandom));
            bn = $signed(6'($urandom));
        end else if (m == 4) begin
            if ($urandom_range(1, 0)) ad = 0; else bd = 0;
        end else if (m == 5) begin
            bw = -aw;
            bn = -an;
            bd = ad;
        end
        if (ad == 0 && m != 4) ad = 1;
        if (bd == 0 && m != 4) bd = 1;
        send_word(aw, an, ad, bw, bn, bd);
    endtask

    task automatic wait_drained;
        i_valid <= 1'b0;
        while (sum_queue.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // receiver stall
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= recv_idle_pct != 0 && $urandom_range(99, 0) < recv_idle_pct;
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_sum e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (sum_queue.size() == 0) begin
                $error("result word with no expected sum");
                fail_count++;
            end else begin
                e = sum_queue.pop_front();
                if (o_div_error !== e.div_error) begin
                    $error("div_error exp %0d got %0d", e.div_error, o_div_error);
                    fail_count++;
                end
                if (o_negative !== e.negative) begin
                    $error("negative exp %0d got %0d", e.negative, o_negative);
                    fail_count++;
                end
                if (o_whole_mag !== e.whole_mag) begin
                    $error("whole_mag exp %0d got %0d", e.whole_mag, o_whole_mag);
                    fail_count++;
                end
                if (o_frac_num !== e.frac_num) begin
                    $error("frac_num exp %0d got %0d", e.frac_num, o_frac_num);
                    fail_count++;
                end
                if (o_frac_den !== e.frac_den) begin
                    $error("frac_den exp %0d got %0d", e.frac_den, o_frac_den);
                    fail_count++;
                end
            end
        end
    end

    task automatic test_directed;
        send_word(0, 0, 1, 0, 0, 1);
        send_word(1, 1, 2, 1, 1, 3);
        send_word(-1, 1, 2, 0, 0, 1);
        send_word(2, -7, 3, -1, 5, 4);
        send_word(0, 5, 0, 1, 1, 1);
        send_word(0, 1, 1, 0, 1, 0);
        send_word(-32768, -32768, 1, -32768, -32768, 1);
        send_word(32767, 32767, 1, 32767, 32767, 1);
        send_word(32767, 32767, 65535, 32767, 32767, 65534);
        send_word(-32768, -32768, 65535, -32768, -32768, 65533);
        send_word(-32768, 32767, 65535, 32767, -32768, 65521);
        send_word(0, 1, 65535, 0, -1, 65535);
        send_word(3, 1, 4, -3, -1, 4);
        send_word(0, 65535 - 65536, 3, 0, 2, 3);
        send_word(0, 3, 4, 0, 3, 4);
        send_word(-5, -1, 6, 0, 0, 65535);
        wait_drained();
    endtask

    task automatic test_random(int n, int s_pct, int r_pct);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        repeat (n) send_random();
        wait_drained();
    endtask

    task automatic test_backpressure;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_cycles = 2000;
        repeat (10) send_random();
        wait_drained();
        // sender pauses until everything has come back
        repeat (20) begin
            send_random();
            wait_drained();
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(400, 16, 57);
        test_random(400, 57, 16);
        test_backpressure();
        test_random(400, 0, 0);
        repeat (600) @(posedge i_clk);
        if (fail_count == 0 && sum_queue.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // run limit
    initial begin
        #200_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
`default_nettype wire

[mixed_fraction_adder.f]
design/mfa_pkg.sv
design/mfa_divider.sv
design/mixed_fraction_adder.sv
tb/mixed_fraction_adder_test.sv
